// ----- rtl/qsst_pkg.sv -----
// Shared types and constants for the quadtree square split test block.
`timescale 1ns / 1ps

package qsst_pkg;

    localparam logic [1:0] KIND_LEAF  = 2'd0;
    localparam logic [1:0] KIND_CHILD = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TEST  = 1'b1;

    localparam logic [1:0] CHILD_LAST = 2'd3;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       base_ld;
        logic       wr;
        logic       rd;
        logic       emit;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic empty;
        logic prep_done;
        logic scan_last;
        logic single;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/quadtree_square_split_test_top.sv -----
// Top level of the quadtree square split test block.
`timescale 1ns / 1ps

// Holds an IMG_ROWS x IMG_COLS image of 8-bit pixels in one RAM. A request with
// func 0 stores one pixel; a request with func 1 tests the square at (row, col) of
// size rows_span x cols_span, scanned row-major. A uniform square returns one leaf
// result with its value; a mixed one returns its four quadrants (floor half first,
// remainder half second), the fourth marked last; a zero-area square returns one
// empty result. Row and column wrap at the image edges. Pixels never written read
// as unknown. One request is in work at a time; the input is stalled from the
// cycle after acceptance until the last result is loaded into the output register,
// and a new request may be taken while that result still waits. Per request:
// first the origin is reduced into the image, one subtract per cycle, row and
// column together (none when the image is 256 or larger in that direction). A
// write then sets the row base and stores the pixel. A test sets the row base,
// reads one pixel per cycle through the RAM read port and waits for the last read
// data, then loads each result once the output register is free; a zero-area test
// stops the reduction at once, skips the scan and loads its one empty result.
module quadtree_square_split_test_top #(
    parameter int IMG_ROWS = 256,
    parameter int IMG_COLS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [7:0] i_row,
    input  logic [7:0] i_col,
    input  logic [7:0] i_pixel,
    input  logic [8:0] i_rows_span,
    input  logic [8:0] i_cols_span,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_value,
    output logic [7:0] o_out_row,
    output logic [7:0] o_out_col,
    output logic [8:0] o_out_rows,
    output logic [8:0] o_out_cols,
    output logic       o_out_last
);
    import qsst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence each request: latch, reduce origin, set row base, then write or scan and emit results
    qsst_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    // Image memory, scan counters, compare and result register
    qsst_dpath #(
        .IMG_ROWS(IMG_ROWS),
        .IMG_COLS(IMG_COLS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_func     (i_func),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_pixel    (i_pixel),
        .i_rows_span(i_rows_span),
        .i_cols_span(i_cols_span),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_kind (o_out_kind),
        .o_out_value(o_out_value),
        .o_out_row  (o_out_row),
        .o_out_col  (o_out_col),
        .o_out_rows (o_out_rows),
        .o_out_cols (o_out_cols),
        .o_out_last (o_out_last)
    );

endmodule

// ----- rtl/qsst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module qsst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/qsst_dpath.sv -----
// Datapath: request latch, coordinate wrap, scan counters, pixel compare, result register.
`timescale 1ns / 1ps

module qsst_dpath #(
    parameter int IMG_ROWS = 256,
    parameter int IMG_COLS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qsst_pkg::t_cmd    i_cmd,
    output qsst_pkg::t_sts    o_sts,
    input  logic              i_func,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_col,
    input  logic [7:0]        i_pixel,
    input  logic [8:0]        i_rows_span,
    input  logic [8:0]        i_cols_span,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_out_kind,
    output logic [7:0]        o_out_value,
    output logic [7:0]        o_out_row,
    output logic [7:0]        o_out_col,
    output logic [8:0]        o_out_rows,
    output logic [8:0]        o_out_cols,
    output logic              o_out_last
);
    import qsst_pkg::*;

    localparam int DEPTH = IMG_ROWS * IMG_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(IMG_ROWS);
    localparam int CW    = $clog2(IMG_COLS);

    logic          r_func;
    logic [7:0]    r_r0, r_c0, r_pixel;
    logic [8:0]    r_nr, r_nc;
    logic          r_empty;
    logic [7:0]    r_rred, r_cred;
    logic [RW-1:0] r_ridx;
    logic [CW-1:0] r_cidx, r_cidx0;
    logic [AW-1:0] r_base;
    logic [8:0]    r_i, r_j;
    logic          r_dv, r_is_first, r_uniform;
    logic [7:0]    r_first;
    logic          r_ovalid;
    logic [1:0]    r_okind;
    logic [7:0]    r_ovalue, r_orow, r_ocol;
    logic [8:0]    r_orows, r_ocols;
    logic          r_olast;

    logic          row_hi, col_hi;
    logic [AW-1:0] addr;
    logic [7:0]    rdata;
    logic [8:0]    hr, hc, rr, rc;
    logic [1:0]    e_kind;
    logic [7:0]    e_value, e_row, e_col;
    logic [8:0]    e_rows, e_cols;
    logic          e_last;

    assign row_hi = (32'(r_rred) >= 32'(IMG_ROWS));
    assign col_hi = (32'(r_cred) >= 32'(IMG_COLS));
    assign addr   = r_base + AW'(r_cidx);

    qsst_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_img (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr),
        .i_waddr(addr),
        .i_wdata(r_pixel),
        .i_re   (i_cmd.rd),
        .i_raddr(addr),
        .o_rdata(rdata)
    );

    // Request latch, scan counters and coordinate wrap
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_r0    <= i_row;
            r_c0    <= i_col;
            r_pixel <= i_pixel;
            r_nr    <= i_rows_span;
            r_nc    <= i_cols_span;
            r_empty <= (i_rows_span == 9'd0) || (i_cols_span == 9'd0);
            r_rred  <= i_row;
            r_cred  <= i_col;
        end else if (i_cmd.prep) begin
            if (row_hi) begin
                r_rred <= r_rred - 8'(IMG_ROWS);
            end
            if (col_hi) begin
                r_cred <= r_cred - 8'(IMG_COLS);
            end
        end
        if (i_cmd.base_ld) begin
            r_ridx  <= RW'(r_rred);
            r_cidx  <= CW'(r_cred);
            r_cidx0 <= CW'(r_cred);
            r_base  <= AW'(r_rred) * AW'(IMG_COLS);
            r_i     <= 9'd0;
            r_j     <= 9'd0;
        end else if (i_cmd.rd) begin
            if (r_j == r_nc - 9'd1) begin
                r_j    <= 9'd0;
                r_i    <= r_i + 9'd1;
                r_cidx <= r_cidx0;
                if (r_ridx == RW'(IMG_ROWS - 1)) begin
                    r_ridx <= '0;
                    r_base <= '0;
                end else begin
                    r_ridx <= r_ridx + RW'(1);
                    r_base <= r_base + AW'(IMG_COLS);
                end
            end else begin
                r_j <= r_j + 9'd1;
                if (r_cidx == CW'(IMG_COLS - 1)) begin
                    r_cidx <= '0;
                end else begin
                    r_cidx <= r_cidx + CW'(1);
                end
            end
        end
    end

    // Pixel compare against the first pixel of the square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= i_cmd.rd;
        end
        if (i_cmd.load) begin
            r_is_first <= 1'b1;
            r_uniform  <= 1'b1;
        end else if (r_dv) begin
            if (r_is_first) begin
                r_first    <= rdata;
                r_is_first <= 1'b0;
            end else if (rdata != r_first) begin
                r_uniform <= 1'b0;
            end
        end
    end

    // Result selection
    always_comb begin
        hr      = r_nr >> 1;
        hc      = r_nc >> 1;
        rr      = r_nr - hr;
        rc      = r_nc - hc;
        e_kind  = KIND_CHILD;
        e_value = 8'd0;
        e_row   = r_r0;
        e_col   = r_c0;
        e_rows  = r_nr;
        e_cols  = r_nc;
        e_last  = 1'b1;
        if (r_empty) begin
            e_kind = KIND_EMPTY;
        end else if (r_uniform) begin
            e_kind  = KIND_LEAF;
            e_value = r_first;
        end else begin
            e_last = (i_cmd.k == CHILD_LAST);
            case (i_cmd.k)
                2'd0: begin
                    e_rows = hr;
                    e_cols = hc;
                end
                2'd1: begin
                    e_row  = r_r0 + hr[7:0];
                    e_rows = rr;
                    e_cols = hc;
                end
                2'd2: begin
                    e_col  = r_c0 + hc[7:0];
                    e_rows = hr;
                    e_cols = rc;
                end
                default: begin
                    e_row  = r_r0 + hr[7:0];
                    e_col  = r_c0 + hc[7:0];
                    e_rows = rr;
                    e_cols = rc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_okind  <= e_kind;
            r_ovalue <= e_value;
            r_orow   <= e_row;
            r_ocol   <= e_col;
            r_orows  <= e_rows;
            r_ocols  <= e_cols;
            r_olast  <= e_last;
        end
    end

    assign o_sts.is_write  = (r_func == FUNC_WRITE);
    assign o_sts.empty     = r_empty;
    assign o_sts.prep_done = !row_hi && !col_hi;
    assign o_sts.scan_last = (r_i == r_nr - 9'd1) && (r_j == r_nc - 9'd1);
    assign o_sts.single    = r_empty || r_uniform;
    assign o_sts.out_free  = !r_ovalid || !i_stall;

    assign o_valid     = r_ovalid;
    assign o_out_kind  = r_okind;
    assign o_out_value = r_ovalue;
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;
    assign o_out_rows  = r_orows;
    assign o_out_cols  = r_ocols;
    assign o_out_last  = r_olast;

endmodule

// ----- rtl/qsst_ctrl.sv -----
// Controller state machine: sequences reduce, base, write or scan, and result emission.
`timescale 1ns / 1ps

module qsst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  qsst_pkg::t_sts i_sts,
    output qsst_pkg::t_cmd o_cmd
);
    import qsst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_BASE,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_stall;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.k = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (!i_sts.is_write && i_sts.empty) begin
                    n_k     = 2'd0;
                    n_state = S_EMIT;
                end else if (i_sts.prep_done) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.base_ld = 1'b1;
                n_state       = i_sts.is_write ? S_WRITE : S_SCAN;
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_k     = 2'd0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.single || r_k == CHILD_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without blocking the next one");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_single_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.single) |-> (r_k == 2'd0))
        else $error("more than one result for a leaf or empty square");

    a_scan_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_last) |=> (r_state == S_DRAIN))
        else $error("scan did not end after its last read");

endmodule
